// ----- rtl/itr_pkg.sv -----
// itr_pkg: shared constants, types and the digit-to-ASCII function for the
// integer_to_radix_text block. No dependencies.
package itr_pkg;

  localparam int unsigned ItrValueWidth = 64;
  localparam int unsigned InWidth       = 64;
  localparam int unsigned RadixWidth    = 6;
  localparam int unsigned CharWidth     = 8;
  localparam int unsigned DigitWidth    = 6;

  localparam logic [RadixWidth-1:0] RadixMin = 6'd2;
  localparam logic [RadixWidth-1:0] RadixMax = 6'd36;
  localparam logic [RadixWidth-1:0] RadixDec = 6'd10;
  localparam logic [RadixWidth-1:0] RadixHex = 6'd16;
  localparam logic [RadixWidth-1:0] RadixOct = 6'd8;

  localparam logic [CharWidth-1:0] ChZero  = 8'h30;
  localparam logic [CharWidth-1:0] ChUpA   = 8'h41;
  localparam logic [CharWidth-1:0] ChX     = 8'h78;
  localparam logic [CharWidth-1:0] ChMinus = 8'h2d;
  localparam logic [CharWidth-1:0] ChNul   = 8'h00;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_BAD,
    EM_MINUS,
    EM_ZERO,
    EM_X,
    EM_DIGIT
  } emit_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_MINUS,
    S_ZERO,
    S_X,
    S_READ,
    S_EMIT
  } itr_state_e;

  typedef struct packed {
    logic      load;
    logic      div_step;
    logic      store;
    logic      ptr_dec;
    emit_sel_e emit;
  } itr_cmd_t;

  typedef struct packed {
    logic bad_radix;
    logic step_last;
    logic quot_zero;
    logic minus;
    logic hex;
    logic oct;
    logic ptr_zero;
  } itr_status_t;

  function automatic logic [CharWidth-1:0] digit_char(input logic [DigitWidth-1:0] d);
    logic [CharWidth-1:0] ext;
    ext = {{(CharWidth-DigitWidth){1'b0}}, d};
    if (d > 6'd9) begin
      digit_char = ChUpA + ext - 8'd10;
    end else begin
      digit_char = ChZero + ext;
    end
  endfunction

endpackage

// ----- rtl/integer_to_radix_text.sv -----
// integer_to_radix_text: top level, integer to ASCII text in base 2..36.
// Depends on itr_pkg, itr_ctrl and itr_dpath.
//
// Usage: drive value_bits_i, is_signed_i and radix_i with start_i high while
// busy_o is low; the word is taken at that clock edge. Characters come out
// most significant first on text_char_o, one per cycle in which
// result_valid_o is high, with last_char_o on the final one. Base 16 leads
// with "0x", base 8 with "0", signed negative base 10 with "-".
// An invalid base gives one word (NUL, last, bad_radix_o) in the next cycle
// and busy_o stays low.
// Each digit is built in the bit-serial divider (one quotient bit per cycle)
// and written to the digit memory; then each prefix character is output,
// and each digit is read from the registered digit memory, then output.
// The receiver cannot stall: every word is shown for exactly one cycle.
// Reset clears the sequencer and the output strobe; the digit memory is not
// cleared.
module integer_to_radix_text #(
  parameter int unsigned VALUE_WIDTH = itr_pkg::ItrValueWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [itr_pkg::InWidth-1:0]    value_bits_i,
  input  logic                           is_signed_i,
  input  logic [itr_pkg::RadixWidth-1:0] radix_i,
  output logic                           result_valid_o,
  output logic [itr_pkg::CharWidth-1:0]  text_char_o,
  output logic                           last_char_o,
  output logic                           bad_radix_o
);
  import itr_pkg::*;

  itr_cmd_t    cmd;
  itr_status_t status;

  itr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  itr_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_bits_i   (value_bits_i),
    .is_signed_i    (is_signed_i),
    .radix_i        (radix_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .text_char_o    (text_char_o),
    .last_char_o    (last_char_o),
    .bad_radix_o    (bad_radix_o)
  );

endmodule

// ----- rtl/itr_dpath.sv -----
// itr_dpath: operand registers, bit-serial restoring divider, digit memory and
// registered result port. Depends on itr_pkg; driven by itr_ctrl commands.
module itr_dpath #(
  parameter int unsigned VALUE_WIDTH = itr_pkg::ItrValueWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [itr_pkg::InWidth-1:0]   value_bits_i,
  input  logic                          is_signed_i,
  input  logic [itr_pkg::RadixWidth-1:0] radix_i,
  input  itr_pkg::itr_cmd_t             cmd_i,
  output itr_pkg::itr_status_t          status_o,
  output logic                          result_valid_o,
  output logic [itr_pkg::CharWidth-1:0] text_char_o,
  output logic                          last_char_o,
  output logic                          bad_radix_o
);
  import itr_pkg::*;

  localparam int unsigned AW = $clog2(VALUE_WIDTH);
  localparam logic [AW-1:0] StepFirst = AW'(VALUE_WIDTH - 1);

  logic [VALUE_WIDTH-1:0] quot_q, quot_d;
  logic [DigitWidth-1:0]  rem_q, rem_d;
  logic [RadixWidth-1:0]  radix_q;
  logic [AW-1:0]          step_q, step_d;
  logic [AW-1:0]          wr_idx_q, wr_idx_d;
  logic [AW-1:0]          ptr_q, ptr_d;
  logic                   minus_q, minus_d;
  logic                   hex_q, oct_q;
  logic [DigitWidth-1:0]  mem_q [VALUE_WIDTH];
  logic [DigitWidth-1:0]  rd_data_q;

  logic                   valid_q, valid_d;
  logic [CharWidth-1:0]   char_q, char_d;
  logic                   last_q, last_d;
  logic                   bad_q, bad_d;

  logic [VALUE_WIDTH-1:0] in_val;
  logic                   in_neg;
  logic [DigitWidth:0]    rem_shift;
  logic                   rem_ge;

  assign in_val    = value_bits_i[VALUE_WIDTH-1:0];
  assign in_neg    = is_signed_i && (radix_i == RadixDec) && in_val[VALUE_WIDTH-1];
  assign rem_shift = {rem_q, quot_q[VALUE_WIDTH-1]};
  assign rem_ge    = rem_shift >= {1'b0, radix_q};

  always_comb begin
    quot_d   = quot_q;
    rem_d    = rem_q;
    step_d   = step_q;
    wr_idx_d = wr_idx_q;
    ptr_d    = ptr_q;
    minus_d  = minus_q;
    if (cmd_i.load) begin
      quot_d   = in_neg ? (~in_val + 1'b1) : in_val;
      rem_d    = '0;
      step_d   = StepFirst;
      wr_idx_d = '0;
      minus_d  = in_neg;
    end
    if (cmd_i.div_step) begin
      quot_d = {quot_q[VALUE_WIDTH-2:0], rem_ge};
      rem_d  = rem_ge ? DigitWidth'(rem_shift - {1'b0, radix_q})
                      : rem_shift[DigitWidth-1:0];
      step_d = step_q - 1'b1;
    end
    if (cmd_i.store) begin
      rem_d    = '0;
      step_d   = StepFirst;
      wr_idx_d = wr_idx_q + 1'b1;
      ptr_d    = wr_idx_q;
    end
    if (cmd_i.ptr_dec) begin
      ptr_d = ptr_q - 1'b1;
    end
  end

  always_comb begin
    valid_d = 1'b1;
    char_d  = ChNul;
    last_d  = 1'b0;
    bad_d   = 1'b0;
    case (cmd_i.emit)
      EM_NONE:  valid_d = 1'b0;
      EM_BAD: begin
        last_d = 1'b1;
        bad_d  = 1'b1;
      end
      EM_MINUS: char_d = ChMinus;
      EM_ZERO:  char_d = ChZero;
      EM_X:     char_d = ChX;
      EM_DIGIT: begin
        char_d = digit_char(rd_data_q);
        last_d = (ptr_q == '0);
      end
      default:  valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q   <= '0;
      rem_q    <= '0;
      step_q   <= '0;
      wr_idx_q <= '0;
      ptr_q    <= '0;
      minus_q  <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      quot_q   <= quot_d;
      rem_q    <= rem_d;
      step_q   <= step_d;
      wr_idx_q <= wr_idx_d;
      ptr_q    <= ptr_d;
      minus_q  <= minus_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      radix_q <= radix_i;
      hex_q   <= (radix_i == RadixHex);
      oct_q   <= (radix_i == RadixOct);
    end
    char_q <= char_d;
    last_q <= last_d;
    bad_q  <= bad_d;
  end

  // digit memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_q[wr_idx_q] <= rem_q;
    end
    rd_data_q <= mem_q[ptr_q];
  end

  assign status_o.bad_radix = (radix_i < RadixMin) || (radix_i > RadixMax);
  assign status_o.step_last = (step_q == '0);
  assign status_o.quot_zero = (quot_q == '0);
  assign status_o.minus     = minus_q;
  assign status_o.hex       = hex_q;
  assign status_o.oct       = oct_q;
  assign status_o.ptr_zero  = (ptr_q == '0);

  assign result_valid_o = valid_q;
  assign text_char_o    = char_q;
  assign last_char_o    = last_q;
  assign bad_radix_o    = bad_q;

endmodule

// ----- rtl/itr_ctrl.sv -----
// itr_ctrl: sequencer for load, per-digit division, prefix and digit output.
// Depends on itr_pkg; talks to itr_dpath through command and status structs.
module itr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  itr_pkg::itr_status_t status_i,
  output itr_pkg::itr_cmd_t    cmd_o,
  output logic                 busy_o
);
  import itr_pkg::*;

  itr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '{load: 1'b0, div_step: 1'b0, store: 1'b0, ptr_dec: 1'b0, emit: EM_NONE};
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (status_i.bad_radix) begin
            cmd_o.emit = EM_BAD;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.step_last) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        if (!status_i.quot_zero) begin
          state_d = S_DIV;
        end else if (status_i.minus) begin
          state_d = S_MINUS;
        end else if (status_i.hex || status_i.oct) begin
          state_d = S_ZERO;
        end else begin
          state_d = S_READ;
        end
      end
      S_MINUS: begin
        cmd_o.emit = EM_MINUS;
        state_d    = S_READ;
      end
      S_ZERO: begin
        cmd_o.emit = EM_ZERO;
        state_d    = status_i.hex ? S_X : S_READ;
      end
      S_X: begin
        cmd_o.emit = EM_X;
        state_d    = S_READ;
      end
      S_READ: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit    = EM_DIGIT;
        cmd_o.ptr_dec = 1'b1;
        state_d       = status_i.ptr_zero ? S_IDLE : S_READ;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- rtl/itr_checker.sv -----
// itr_checker: port-level assertions for integer_to_radix_text, bound to the
// top level below. Depends on itr_pkg.
module itr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic [itr_pkg::RadixWidth-1:0] radix_i,
  input logic                           result_valid_o,
  input logic [itr_pkg::CharWidth-1:0]  text_char_o,
  input logic                           last_char_o,
  input logic                           bad_radix_o
);
  import itr_pkg::*;

  logic take, bad_in;
  assign take   = start_i && !busy_o;
  assign bad_in = (radix_i < RadixMin) || (radix_i > RadixMax);

  a_bad_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && bad_radix_o |-> last_char_o && (text_char_o == ChNul))
    else $error("bad radix word not a lone NUL");

  a_bad_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && bad_in |=> result_valid_o && bad_radix_o && !busy_o)
    else $error("invalid base not answered next cycle");

  a_good_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !bad_in |=> busy_o && !result_valid_o)
    else $error("valid item did not start conversion");

  a_good_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !bad_radix_o |-> (text_char_o != ChNul))
    else $error("NUL character in valid text");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> result_valid_o && last_char_o && !bad_radix_o)
    else $error("conversion ended without final character");

endmodule

bind integer_to_radix_text itr_checker u_itr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .radix_i        (radix_i),
  .result_valid_o (result_valid_o),
  .text_char_o    (text_char_o),
  .last_char_o    (last_char_o),
  .bad_radix_o    (bad_radix_o)
);

// ----- test/tb.sv -----
// tb: self-checking bench for integer_to_radix_text. Predicts the character
// stream of every accepted word and checks each strobed result in order.
// Depends on itr_pkg and the integer_to_radix_text RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import itr_pkg::*;

  localparam int unsigned VW = ItrValueWidth;
  localparam int RandomWords = 400;
  localparam int QuietTail = 60;

  typedef struct packed {
    logic [CharWidth-1:0] ch;
    logic                 last;
    logic                 bad;
  } text_word_t;

  class radix_text_checker;
    text_word_t pending_chars[$];
    int         mismatches;

    function void note_request(logic [InWidth-1:0] raw, logic sgn,
                               logic [RadixWidth-1:0] radix);
      logic [63:0] mask;
      logic [63:0] mag;
      logic [63:0] base;
      logic [DigitWidth-1:0] digs[$];
      logic [DigitWidth-1:0] d;
      logic [CharWidth-1:0] ch;
      logic neg;
      int k;
      mask = {64{1'b1}} >> (64 - VW);
      if (radix < RadixMin || radix > RadixMax) begin
        pending_chars.push_back('{ChNul, 1'b1, 1'b1});
        return;
      end
      mag = raw & mask;
      base = 64'(radix);
      neg = sgn && radix == RadixDec && mag[VW-1];
      if (neg) begin
        mag = (~mag + 64'd1) & mask;
      end
      do begin
        digs.push_back(DigitWidth'(mag % base));
        mag = mag / base;
      end while (mag != 0 && digs.size() < 64);
      if (neg) begin
        pending_chars.push_back('{ChMinus, 1'b0, 1'b0});
      end
      if (radix == RadixHex) begin
        pending_chars.push_back('{ChZero, 1'b0, 1'b0});
        pending_chars.push_back('{ChX, 1'b0, 1'b0});
      end else if (radix == RadixOct) begin
        pending_chars.push_back('{ChZero, 1'b0, 1'b0});
      end
      for (k = digs.size() - 1; k >= 0; k--) begin
        d = digs[k];
        ch = (d > 9) ? ChUpA + CharWidth'(d) - 8'd10 : ChZero + CharWidth'(d);
        pending_chars.push_back('{ch, k == 0, 1'b0});
      end
    endfunction

    function void check_char(text_word_t got);
      text_word_t want;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: char %h last %b bad %b", got.ch, got.last, got.bad);
        end
        return;
      end
      want = pending_chars.pop_front();
      if (got.ch !== want.ch || got.last !== want.last || got.bad !== want.bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("word mismatch: expected char %h last %b bad %b, got char %h last %b bad %b",
                   want.ch, want.last, want.bad, got.ch, got.last, got.bad);
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [InWidth-1:0]    value_bits_i;
  logic                  is_signed_i;
  logic [RadixWidth-1:0] radix_i;
  logic                  result_valid_o;
  logic [CharWidth-1:0]  text_char_o;
  logic                  last_char_o;
  logic                  bad_radix_o;

  radix_text_checker text_check = new();

  integer_to_radix_text dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_bits_i  (value_bits_i),
    .is_signed_i   (is_signed_i),
    .radix_i       (radix_i),
    .result_valid_o(result_valid_o),
    .text_char_o   (text_char_o),
    .last_char_o   (last_char_o),
    .bad_radix_o   (bad_radix_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      text_check.check_char('{text_char_o, last_char_o, bad_radix_o});
    end
  end

  task automatic send_word(input logic [InWidth-1:0] raw, input logic sgn,
                           input logic [RadixWidth-1:0] radix);
    start_i      <= 1'b1;
    value_bits_i <= raw;
    is_signed_i  <= sgn;
    radix_i      <= radix;
    do @(posedge clk_i); while (busy_o);
    text_check.note_request(raw, sgn, radix);
  endtask

  // hold start low; optionally let the current conversion finish first
  task automatic idle_burst(input int unsigned cycles, input bit after_busy);
    start_i      <= 1'b0;
    value_bits_i <= {$urandom, $urandom};
    radix_i      <= RadixWidth'($urandom);
    if (after_busy) begin
      do @(posedge clk_i); while (busy_o);
    end
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (text_check.pending_chars.size() != 0);
  endtask

  function automatic logic [InWidth-1:0] random_value();
    logic [InWidth-1:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: random_value = r;
      1: random_value = InWidth'($urandom_range(0, 99));
      2: random_value = r >> $urandom_range(1, 63);
      3: random_value = ~(r >> $urandom_range(8, 63));
      default: begin
        case ($urandom_range(0, 3))
          0: random_value = '0;
          1: random_value = '1;
          2: random_value = {1'b1, {(InWidth-1){1'b0}}};
          default: random_value = {1'b0, {(InWidth-1){1'b1}}};
        endcase
      end
    endcase
  endfunction

  function automatic logic [RadixWidth-1:0] random_radix();
    case ($urandom_range(0, 9))
      0: begin
        if ($urandom_range(0, 2) == 0) begin
          random_radix = RadixWidth'($urandom_range(0, int'(RadixMin) - 1));
        end else begin
          random_radix = RadixWidth'($urandom_range(int'(RadixMax) + 1,
                                                    (1 << RadixWidth) - 1));
        end
      end
      1: random_radix = RadixDec;
      2: random_radix = RadixHex;
      3: random_radix = RadixOct;
      4: random_radix = RadixMin;
      default: random_radix = RadixWidth'($urandom_range(RadixMin, RadixMax));
    endcase
  endfunction

  initial begin
    int n;
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    value_bits_i <= '0;
    is_signed_i  <= 1'b0;
    radix_i      <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word('0, 1'b0, RadixDec);
    send_word('0, 1'b1, RadixDec);
    send_word('0, 1'b0, RadixHex);
    send_word('0, 1'b0, RadixOct);
    send_word('1, 1'b0, RadixMin);
    send_word('1, 1'b0, RadixMax);
    send_word('1, 1'b0, RadixDec);
    send_word('1, 1'b1, RadixDec);
    send_word({1'b1, {(InWidth-1){1'b0}}}, 1'b1, RadixDec);
    send_word({1'b0, {(InWidth-1){1'b1}}}, 1'b1, RadixDec);
    send_word('1, 1'b1, RadixHex);
    send_word({1'b1, {(InWidth-1){1'b0}}}, 1'b1, RadixOct);
    send_word(64'd35, 1'b0, RadixMax);
    send_word(64'hDEAD_BEEF, 1'b0, RadixHex);
    send_word(~64'd12344, 1'b1, RadixDec);
    send_word(64'd12345, 1'b1, RadixDec);
    send_word(64'd1, 1'b0, RadixMin + 6'd1);
    send_word('0, 1'b0, '0);
    send_word('1, 1'b1, RadixMin - 6'd1);
    send_word('0, 1'b0, RadixMax + 6'd1);
    send_word('1, 1'b1, '1);
    send_word(64'hFFFF, 1'b1, RadixMin);
    drain();

    for (n = 0; n < RandomWords; n++) begin
      send_word(random_value(), 1'($urandom_range(0, 1)), random_radix());
      if (n == RandomWords / 2) begin
        drain();
      end else if (n < RandomWords - QuietTail && (n % 50) >= 20
                   && $urandom_range(0, 2) == 0) begin
        idle_burst($urandom_range(1, 19), 1'($urandom_range(0, 1)));
      end
    end
    drain();
    repeat (VW + 20) @(posedge clk_i);

    if (text_check.mismatches == 0 && text_check.pending_chars.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
